/* design/seq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted event queue package
// Command and status codes and the control and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package seq_pkg;

   localparam int KEY_BITS    = 31;
   localparam int CMD_BITS    = 3;
   localparam int STATUS_BITS = 2;

   typedef logic [CMD_BITS-1:0]    command_type;
   typedef logic [STATUS_BITS-1:0] status_type;

   localparam command_type CMD_INSERT    = 3'd0;
   localparam command_type CMD_PUSH_NEXT = 3'd1;
   localparam command_type CMD_PUSH_LAST = 3'd2;
   localparam command_type CMD_POP       = 3'd3;
   localparam command_type CMD_CLEAR     = 3'd4;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

   // Controller to datapath.
   typedef struct packed {
      logic load;    // capture the accepted request
      logic exec;    // first step of the command
      logic scan;    // one step of the sorted insert scan
      logic emit;    // load the response register
   } seq_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic insert_go;   // the held command is an insert with room left
      logic scan_done;   // the new entry is written in this cycle
   } seq_stat_type;

endpackage
`default_nettype wire

/* design/seq_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted event queue datapath
// Circular entry memory, head pointer and count, insert scan registers and
// the response register.
// ----------------------------------------------------------------------------
module seq_datapath
   import seq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 64,
   parameter int HANDLE_BITS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire seq_cmd_type                     ctrl,
   output seq_stat_type                         stat,
   input  wire command_type                     req_command,
   input  wire logic [KEY_BITS-1:0]             req_event_key,
   input  wire logic [HANDLE_BITS-1:0]          req_event_handle,
   input  wire logic                            req_one_shot,
   output status_type                           rsp_status,
   output logic [KEY_BITS-1:0]                  rsp_popped_key,
   output logic [HANDLE_BITS-1:0]               rsp_popped_handle,
   output logic                                 rsp_popped_one_shot,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]     rsp_entry_count
);

   localparam int IDX_W   = $clog2(QUEUE_DEPTH);
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W   = IDX_W + 1;
   localparam int ENTRY_W = KEY_BITS + HANDLE_BITS + 1;

   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [ENTRY_W-1:0] entry_type;

   function automatic idx_type idx_inc(input idx_type idx);
      idx_type res;
      if (idx == IDX_W'(QUEUE_DEPTH - 1)) res = '0;
      else res = idx + IDX_W'(1);
      return res;
   endfunction

   function automatic idx_type idx_dec(input idx_type idx);
      idx_type res;
      if (idx == '0) res = IDX_W'(QUEUE_DEPTH - 1);
      else res = idx - IDX_W'(1);
      return res;
   endfunction

   entry_type   mem_ff [QUEUE_DEPTH];
   entry_type   rd_data_ff;

   command_type cmd_ff;
   logic [KEY_BITS-1:0]    key_ff;
   logic [HANDLE_BITS-1:0] handle_ff;
   logic                   once_ff;

   idx_type    head_ff, head_in;
   cnt_type    count_ff, count_in;
   idx_type    gap_ff, gap_in;
   cnt_type    left_ff, left_in;
   logic       rd_pend_ff, rd_pend_in;
   status_type status_ff, status_in;
   logic       pop_ok_ff, pop_ok_in;

   status_type             rsp_status_ff;
   logic [KEY_BITS-1:0]    rsp_key_ff;
   logic [HANDLE_BITS-1:0] rsp_handle_ff;
   logic                   rsp_once_ff;
   cnt_type                rsp_count_ff;

   logic       wr_en, rd_en;
   idx_type    wr_addr, rd_addr;
   entry_type  wr_data;
   entry_type  new_entry;
   idx_type    tail, gap_dec;
   logic [SUM_W-1:0] tail_sum;
   logic       full, empty;
   logic [KEY_BITS-1:0] rd_key;

   assign new_entry = {once_ff, handle_ff, key_ff};
   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign rd_key    = rd_data_ff[KEY_BITS-1:0];
   assign gap_dec   = idx_dec(gap_ff);

   // The slot just behind the last entry; head plus count stays below twice
   // the depth, so one conditional subtract wraps it.
   always_comb begin
      tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
      if (tail_sum >= SUM_W'(QUEUE_DEPTH)) tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
      tail = tail_sum[IDX_W-1:0];
   end

   always_comb begin
      head_in        = head_ff;
      count_in       = count_ff;
      gap_in         = gap_ff;
      left_in        = left_ff;
      rd_pend_in     = rd_pend_ff;
      status_in      = status_ff;
      pop_ok_in      = pop_ok_ff;
      wr_en          = 1'b0;
      wr_addr        = gap_ff;
      wr_data        = new_entry;
      rd_en          = 1'b0;
      rd_addr        = head_ff;
      stat.insert_go = (cmd_ff == CMD_INSERT) && !full;
      stat.scan_done = 1'b0;

      if (ctrl.exec) begin
         status_in  = ST_OK;
         pop_ok_in  = 1'b0;
         gap_in     = tail;
         left_in    = count_ff;
         rd_pend_in = 1'b0;
         unique case (cmd_ff)
            CMD_INSERT: begin
               if (full) status_in = ST_FULL;
            end
            CMD_PUSH_NEXT: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  head_in  = idx_dec(head_ff);
                  wr_en    = 1'b1;
                  wr_addr  = idx_dec(head_ff);
                  count_in = count_ff + CNT_W'(1);
               end
            end
            CMD_PUSH_LAST: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = tail;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            CMD_POP: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  rd_en     = 1'b1;
                  rd_addr   = head_ff;
                  head_in   = idx_inc(head_ff);
                  count_in  = count_ff - CNT_W'(1);
                  pop_ok_in = 1'b1;
               end
            end
            CMD_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
      end else if (ctrl.scan) begin
         // Entries with a larger key move one slot back; the new entry fills
         // the gap left behind the first entry that is not larger.
         if (rd_pend_ff && (rd_key > key_ff)) begin
            wr_en   = 1'b1;
            wr_addr = gap_ff;
            wr_data = rd_data_ff;
            gap_in  = gap_dec;
            left_in = left_ff - CNT_W'(1);
            if (left_ff != CNT_W'(1)) begin
               rd_en      = 1'b1;
               rd_addr    = idx_dec(gap_dec);
               rd_pend_in = 1'b1;
            end else begin
               rd_pend_in = 1'b0;
            end
         end else if (rd_pend_ff || (left_ff == '0)) begin
            wr_en          = 1'b1;
            wr_addr        = gap_ff;
            wr_data        = new_entry;
            count_in       = count_ff + CNT_W'(1);
            rd_pend_in     = 1'b0;
            stat.scan_done = 1'b1;
         end else begin
            rd_en      = 1'b1;
            rd_addr    = gap_dec;
            rd_pend_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         count_ff   <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         head_ff    <= head_in;
         count_ff   <= count_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      gap_ff    <= gap_in;
      left_ff   <= left_in;
      status_ff <= status_in;
      pop_ok_ff <= pop_ok_in;
      if (ctrl.load) begin
         cmd_ff    <= req_command;
         key_ff    <= req_event_key;
         handle_ff <= req_event_handle;
         once_ff   <= req_one_shot;
      end
      if (ctrl.emit) begin
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= count_ff;
         if (pop_ok_ff) begin
            rsp_key_ff    <= rd_data_ff[KEY_BITS-1:0];
            rsp_handle_ff <= rd_data_ff[KEY_BITS +: HANDLE_BITS];
            rsp_once_ff   <= rd_data_ff[ENTRY_W-1];
         end else begin
            rsp_key_ff    <= '0;
            rsp_handle_ff <= '0;
            rsp_once_ff   <= 1'b0;
         end
      end
   end

   assign rsp_status          = rsp_status_ff;
   assign rsp_popped_key      = rsp_key_ff;
   assign rsp_popped_handle   = rsp_handle_ff;
   assign rsp_popped_one_shot = rsp_once_ff;
   assign rsp_entry_count     = rsp_count_ff;

endmodule
`default_nettype wire

/* design/seq_control.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted event queue controller
// Sequences one request at a time and owns the response valid flag.
// ----------------------------------------------------------------------------
module seq_control
   import seq_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output seq_cmd_type       ctrl,
   input  wire seq_stat_type stat
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_SCAN = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in  = state_ff;
      ctrl      = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctrl.load = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            ctrl.exec = 1'b1;
            state_in  = stat.insert_go ? S_SCAN : S_DONE;
         end
         S_SCAN: begin
            ctrl.scan = 1'b1;
            if (stat.scan_done) state_in = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               ctrl.emit = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (ctrl.emit) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule
`default_nettype wire

/* design/sorted_event_queue_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted event queue unit
// Bounded time-ordered event queue with sorted insert, push to either end,
// pop and clear; one response for every request.
// ----------------------------------------------------------------------------
// Each request is taken alone. Push next, push last, pop, clear and any
// dropped or ignored request step through accept, execute and loading the
// response register before the unit is ready again. A sorted insert walks
// the queue from the back toward the front through the single read port of
// the entry memory, moving one entry per cycle. The response register lets
// the next request be accepted while a response still waits; the unit
// holds in its final step only if the previous response has not yet been
// taken. The entries live in a circular memory of QUEUE_DEPTH words with a
// head pointer and a count, so nothing needs clearing after reset and a
// clear request only zeroes the count. Only entries below the count are
// ever read.
// ----------------------------------------------------------------------------
module sorted_event_queue_unit
   import seq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 64,
   parameter int HANDLE_BITS = 16,
   localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1),
   localparam int REQ_DATA_W = ((KEY_BITS + HANDLE_BITS + 1 + 7) / 8) * 8,
   localparam int RSP_DATA_W = ((KEY_BITS + HANDLE_BITS + 1 + CNT_W + 7) / 8) * 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   // event_key, event_handle, one_shot, then zero padding
   input  wire logic [REQ_DATA_W-1:0]   req_tdata,
   // command
   input  wire logic [CMD_BITS-1:0]     req_tuser,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   // popped_key, popped_handle, popped_one_shot, entry_count, then zero padding
   output logic [RSP_DATA_W-1:0]        rsp_tdata,
   // status
   output logic [STATUS_BITS-1:0]       rsp_tuser
);

   seq_cmd_type  ctrl;
   seq_stat_type stat;

   logic [KEY_BITS-1:0]    req_key;
   logic [HANDLE_BITS-1:0] req_handle;
   logic                   req_once;

   status_type             rsp_status;
   logic [KEY_BITS-1:0]    rsp_key;
   logic [HANDLE_BITS-1:0] rsp_handle;
   logic                   rsp_once;
   logic [CNT_W-1:0]       rsp_count;

   // Request payload unpacking; bits above the one-shot flag are padding.
   assign req_key    = req_tdata[KEY_BITS-1:0];
   assign req_handle = req_tdata[KEY_BITS +: HANDLE_BITS];
   assign req_once   = req_tdata[KEY_BITS + HANDLE_BITS];

   seq_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctrl       (ctrl),
      .stat       (stat)
   );

   seq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .ctrl                (ctrl),
      .stat                (stat),
      .req_command         (req_tuser),
      .req_event_key       (req_key),
      .req_event_handle    (req_handle),
      .req_one_shot        (req_once),
      .rsp_status          (rsp_status),
      .rsp_popped_key      (rsp_key),
      .rsp_popped_handle   (rsp_handle),
      .rsp_popped_one_shot (rsp_once),
      .rsp_entry_count     (rsp_count)
   );

   assign rsp_tdata = RSP_DATA_W'({rsp_count, rsp_once, rsp_handle, rsp_key});
   assign rsp_tuser = rsp_status;

   // The count reported never exceeds the queue depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_count <= CNT_W'(QUEUE_DEPTH)))
      else $error("entry count above queue depth");

   // A dropped push is only reported when the queue is full.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_status == ST_FULL)) |-> (rsp_count == CNT_W'(QUEUE_DEPTH)))
      else $error("full status with room left");

   // An empty pop reports no entries and zero popped fields.
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_status == ST_EMPTY)) |->
         ((rsp_count == '0) && (rsp_key == '0) && (rsp_handle == '0) && !rsp_once))
      else $error("empty pop with data or entries");

   // A request is never accepted in two consecutive cycles.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while busy");

endmodule
`default_nettype wire

/* test/event_queue_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted event queue checker
// Watches both stream channels of the unit. It keeps its own model of the
// event line, forms the response of every accepted request, and compares
// each accepted response field by field with the oldest one still awaited.
// ----------------------------------------------------------------------------
module event_queue_checker
   import seq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 64,
   parameter int HANDLE_BITS = 16,
   localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1),
   localparam int REQ_DATA_W = ((KEY_BITS + HANDLE_BITS + 1 + 7) / 8) * 8,
   localparam int RSP_DATA_W = ((KEY_BITS + HANDLE_BITS + 1 + CNT_W + 7) / 8) * 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [CMD_BITS-1:0]   req_tuser,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic [STATUS_BITS-1:0] rsp_tuser,
   output int                         mismatch_count,
   output int                         awaited_count
);

   localparam int HANDLE_LSB = KEY_BITS;
   localparam int ONCE_BIT   = KEY_BITS + HANDLE_BITS;
   localparam int COUNT_LSB  = ONCE_BIT + 1;

   typedef struct packed {
      logic [KEY_BITS-1:0]    key;
      logic [HANDLE_BITS-1:0] handle;
      logic                   once;
   } event_entry_type;

   typedef struct packed {
      status_type             status;
      logic [KEY_BITS-1:0]    key;
      logic [HANDLE_BITS-1:0] handle;
      logic                   once;
      logic [CNT_W-1:0]       count;
   } queue_response_type;

   event_entry_type    event_line[$];          // index 0 is the pop end
   queue_response_type awaited_responses[$];

   // Applies one command to the modeled line and returns its response.
   function automatic queue_response_type run_command(command_type cmd,
                                                      event_entry_type ent);
      queue_response_type r;
      int pos;
      r = '0;
      r.status = ST_OK;
      case (cmd) inside
         CMD_INSERT, CMD_PUSH_NEXT, CMD_PUSH_LAST: begin
            if (event_line.size() >= QUEUE_DEPTH) begin
               r.status = ST_FULL;
            end else if (cmd == CMD_INSERT) begin
               // Walk from the back; the entry lands behind the first key
               // that is not greater, so equal keys keep arrival order.
               pos = event_line.size();
               while (pos > 0 && event_line[pos-1].key > ent.key) pos--;
               event_line.insert(pos, ent);
            end else if (cmd == CMD_PUSH_NEXT) begin
               event_line.push_front(ent);
            end else begin
               event_line.push_back(ent);
            end
         end
         CMD_POP: begin
            if (event_line.size() == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.key    = event_line[0].key;
               r.handle = event_line[0].handle;
               r.once   = event_line[0].once;
               void'(event_line.pop_front());
            end
         end
         CMD_CLEAR: begin
            event_line.delete();
         end
         default: begin
         end
      endcase
      r.count = CNT_W'(event_line.size());
      return r;
   endfunction

   task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      queue_response_type got;
      queue_response_type want;
      event_entry_type    ent;
      if (reset) begin
         event_line.delete();
         awaited_responses.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tuser;
            got.key    = rsp_tdata[KEY_BITS-1:0];
            got.handle = rsp_tdata[HANDLE_LSB +: HANDLE_BITS];
            got.once   = rsp_tdata[ONCE_BIT];
            got.count  = rsp_tdata[COUNT_LSB +: CNT_W];
            if (awaited_responses.size() == 0) begin
               $display("%0t: response with none awaited, status %0h count %0h",
                        $time, got.status, got.count);
               mismatch_count++;
            end else begin
               want = awaited_responses.pop_front();
               check_field("status", 32'(want.status), 32'(got.status));
               check_field("popped_key", 32'(want.key), 32'(got.key));
               check_field("popped_handle", 32'(want.handle), 32'(got.handle));
               check_field("popped_one_shot", 32'(want.once), 32'(got.once));
               check_field("entry_count", 32'(want.count), 32'(got.count));
            end
         end
         if (req_tvalid && req_tready) begin
            ent.key    = req_tdata[KEY_BITS-1:0];
            ent.handle = req_tdata[HANDLE_LSB +: HANDLE_BITS];
            ent.once   = req_tdata[ONCE_BIT];
            awaited_responses.push_back(run_command(command_type'(req_tuser), ent));
         end
      end
      awaited_count = awaited_responses.size();
   end

endmodule

/* test/tb_sorted_event_queue_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted event queue unit testbench
// Drives directed and random command requests into the unit with random
// gaps on both channels, including two long response hold-offs that back
// the unit up. The checker beside the unit predicts and compares every
// response; this module only makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_sorted_event_queue_unit;
   import seq_pkg::*;

   localparam int QUEUE_DEPTH = 64;
   localparam int HANDLE_BITS = 16;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int REQ_DATA_W  = ((KEY_BITS + HANDLE_BITS + 1 + 7) / 8) * 8;
   localparam int RSP_DATA_W  = ((KEY_BITS + HANDLE_BITS + 1 + CNT_W + 7) / 8) * 8;

   localparam logic [KEY_BITS-1:0]    KEY_MAX    = {KEY_BITS{1'b1}};
   localparam logic [HANDLE_BITS-1:0] HANDLE_MAX = {HANDLE_BITS{1'b1}};
   // Highest code the command field can carry; codes above clear are unused.
   localparam command_type CMD_TOP_CODE = {CMD_BITS{1'b1}};

   // Idle stretch after the last response before the verdict is given.
   localparam int DRAIN_CYCLES = 20;
   // Length of the response hold-off that makes the unit stall its input.
   localparam int HOLD_OFF_CYCLES = 300;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;   // event_key, event_handle, one_shot, padding
   logic [CMD_BITS-1:0]    req_tuser;   // command
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;   // popped_key, popped_handle, popped_one_shot,
                                        // entry_count, padding
   logic [STATUS_BITS-1:0] rsp_tuser;   // status
   int                     mismatch_count;
   int                     awaited_count;

   sorted_event_queue_unit #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .HANDLE_BITS(HANDLE_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   event_queue_checker #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .HANDLE_BITS(HANDLE_BITS)
   ) queue_check (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .mismatch_count(mismatch_count),
      .awaited_count(awaited_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Idle lengths: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Keys are drawn mostly from a narrow range so that equal keys are common,
   // with full range values and both extremes mixed in.
   function automatic logic [KEY_BITS-1:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return KEY_BITS'($urandom_range(0, 15));
      if (r < 85) return KEY_BITS'($urandom);
      if (r < 93) return '0;
      return KEY_MAX;
   endfunction

   function automatic command_type churn_command();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return CMD_INSERT;
      if (r < 50) return CMD_PUSH_NEXT;
      if (r < 60) return CMD_PUSH_LAST;
      if (r < 95) return CMD_POP;
      if (r < 97) return CMD_CLEAR;
      return command_type'($urandom_range(CMD_CLEAR + 1, CMD_TOP_CODE));
   endfunction

   function automatic command_type fill_command();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return CMD_INSERT;
      if (r < 85) return CMD_PUSH_NEXT;
      return CMD_PUSH_LAST;
   endfunction

   // Offers one request and holds it until the unit accepts it. When the
   // next request follows with no gap, valid simply stays high.
   task automatic send_request(command_type cmd, logic [KEY_BITS-1:0] key,
                               logic [HANDLE_BITS-1:0] handle, logic once);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= REQ_DATA_W'({once, handle, key});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random(command_type cmd);
      send_request(cmd, pick_key(), HANDLE_BITS'($urandom), 1'($urandom));
   endtask

   // Receiver: open stretches of random length, random stalls between them,
   // and twice a long hold-off while the sender keeps offering requests.
   initial begin
      int taken;
      int run;
      int gap;
      int hold_offs;
      taken     = 0;
      hold_offs = 0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 120) : $urandom_range(1, 8);
         rsp_tready <= 1'b1;
         repeat (run) begin
            @(posedge clock);
            if (rsp_tvalid && rsp_tready) taken++;
         end
         if ((hold_offs == 0 && taken >= 150) || (hold_offs == 1 && taken >= 500)) begin
            hold_offs++;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= CMD_INSERT;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. A pop and an unused code on the empty queue come first.
      send_request(CMD_POP, KEY_MAX, HANDLE_MAX, 1'b1);
      send_request(command_type'(CMD_CLEAR + 1), KEY_MAX, HANDLE_MAX, 1'b1);
      // Two equal keys must leave in arrival order.
      send_request(CMD_INSERT, 31'd100, '0, 1'b0);
      send_request(CMD_INSERT, 31'd100, HANDLE_MAX, 1'b1);
      // Smallest and largest keys go to the front and the back.
      send_request(CMD_INSERT, '0, 16'h1234, 1'b1);
      send_request(CMD_INSERT, KEY_MAX, 16'habcd, 1'b0);
      // Pushes leave the line unsorted; later inserts still follow the scan rule.
      send_request(CMD_PUSH_NEXT, 31'd50, 16'h5555, 1'b0);
      send_request(CMD_PUSH_LAST, 31'd1, 16'haaaa, 1'b1);
      send_request(CMD_INSERT, 31'd60, 16'h0f0f, 1'b1);
      send_request(CMD_INSERT, '0, 16'hf0f0, 1'b0);
      send_request(command_type'(CMD_CLEAR + 2), 31'd7, 16'h0001, 1'b0);
      send_request(CMD_TOP_CODE, 31'd7, 16'h8000, 1'b1);
      // Drain all eight entries, then one pop too many.
      repeat (9) send_request(CMD_POP, '0, '0, 1'b0);
      send_request(CMD_PUSH_LAST, KEY_MAX, HANDLE_MAX, 1'b1);
      send_request(CMD_CLEAR, KEY_MAX, HANDLE_MAX, 1'b1);
      send_request(CMD_POP, '0, '0, 1'b0);
      send_request(CMD_PUSH_NEXT, '0, '0, 1'b0);
      send_request(CMD_POP, '0, '0, 1'b0);

      // Random part: mixed traffic, then a fill past full so that requests are
      // dropped, then a drain past empty.
      repeat (3) begin
         repeat (100) send_random(churn_command());
         repeat (QUEUE_DEPTH + 6) send_random(fill_command());
         repeat (QUEUE_DEPTH + 8) begin
            if ($urandom_range(0, 19) == 0)
               send_random(command_type'($urandom_range(CMD_CLEAR + 1, CMD_TOP_CODE)));
            else
               send_random(CMD_POP);
         end
      end
      req_tvalid <= 1'b0;

      // Poll on the falling edge so the checker's counts have settled.
      @(negedge clock);
      while (awaited_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && awaited_count == 0) begin
         $display("tb_sorted_event_queue_unit: clean");
      end else begin
         $display("tb_sorted_event_queue_unit: errors");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #20000000;
      $display("tb_sorted_event_queue_unit: errors");
      $finish;
   end

endmodule
